@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion, disabled while rst is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition that must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_CLK(lbl, clk, rst, !(expr))

`endif

@@ src/lcdnw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

  // timing, in microseconds
  localparam int unsigned STEP_HOLD_US   = 2000;
  localparam int unsigned CLEAR_EXTRA_US = 2000;
  localparam int unsigned HOLD_W         = 12;
  localparam int unsigned HOLD_MAX       = (1 << HOLD_W) - 1;

  function automatic logic [HOLD_W-1:0] sat_hold(input int unsigned us);
    return (us > HOLD_MAX) ? HOLD_W'(HOLD_MAX) : HOLD_W'(us);
  endfunction

  localparam logic [HOLD_W-1:0] HOLD_STEP  = sat_hold(STEP_HOLD_US);
  localparam logic [HOLD_W-1:0] HOLD_CLEAR = sat_hold(STEP_HOLD_US + CLEAR_EXTRA_US);

  // decimal conversion
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  // floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
  localparam logic [NUM_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHIFT = 35;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;

  // LCD command bytes
  localparam logic [7:0] SET_DDRAM = 8'h80;
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam int unsigned INIT_LEN = 6;

  typedef enum logic [1:0] {
    REQ_BYTE   = 2'd0,
    REQ_INIT   = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_NUMBER = 2'd3
  } req_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0E;
      3'd4:    c = CLEAR_CMD;
      3'd5:    c = 8'h06;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // one byte handed from the sequencer to the step generator
  typedef struct packed {
    logic       valid;
    logic       rs;
    logic [7:0] value;
    logic       long_hold;  // last step carries the clear delay
    logic       final_byte; // last byte of the request
  } byte_req_t;

  // divide-by-ten unit status
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DIG_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ src/char_lcd_nibble_writer.sv @@
// Character LCD writer, 4-bit bus.
// Input stream (s_axis): one request per transfer; tuser carries the request
// kind and the command/data flag, tdata the byte, row, column and number.
// Output stream (m_axis): one pin step per transfer: E level, DB7..DB4,
// hold time in microseconds in tdata, RS in tuser, tlast on the final step.
// Each byte yields four steps; init yields 24 steps, a cursor request 4 (or
// none for rows above three), a number 4 per decimal digit.
// Byte, init and cursor requests pass the sequencer state register, then the
// step generator register, before their first step is offered; the step
// generator may first have to finish the previous byte. Numbers first pass
// the divide-by-ten unit, one digit after another. Each step then stays
// valid until the receiver takes it, so the output rate is one step per
// cycle at most, set by m_axis_tready.
// s_axis_tready is high only while the sequencer is idle; the next request
// can be taken once the last byte of the previous one has been handed to the
// step generator, so it can overlap the draining of that byte's steps.
// A stalled receiver freezes the step generator and, through it, the
// sequencer. Reset (rst, synchronous) drops all pending work: no step is
// valid and the block is ready the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // byte_value[7:0], row[10:8], column[16:11],
                                          // number[48:17], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // req_type[1:0], is_data[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // enable[0], nibble[4:1], hold_us[16:5], zero pad
  output logic             m_axis_tuser,  // register_select
  output logic             m_axis_tlast
);
  import lcdnw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,  // digit extraction
    ST_SEND = 3'b100   // feeding bytes to the step generator
  } state_t;

  state_t state;
  req_t   kind;
  logic [7:0]           byte_reg;
  logic                 rs_reg;
  logic [DIG_IDX_W-1:0] ptr;
  logic [DIG_CNT_W-1:0] dcnt;
  logic [DIG_W-1:0]     digits [MAX_DIGITS];

  // request fields
  req_t             in_type;
  logic             in_is_data;
  logic [7:0]       in_byte;
  logic [2:0]       in_row;
  logic [5:0]       in_col;
  logic [NUM_W-1:0] in_number;
  logic             accept;
  logic [7:0]       cursor_addr;

  // divider
  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  div_res_t         div_res;

  // byte hand-off
  byte_req_t        breq;
  logic             breq_ready;
  logic [7:0]       init_byte;
  logic             room;
  logic [DIG_CNT_W-1:0] cnt_new;

  assign in_type    = req_t'(s_axis_tuser[1:0]);
  assign in_is_data = s_axis_tuser[2];
  assign in_byte    = s_axis_tdata[7:0];
  assign in_row     = s_axis_tdata[10:8];
  assign in_col     = s_axis_tdata[16:11];
  assign in_number  = s_axis_tdata[48:17];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cursor_addr   = SET_DDRAM + row_base(in_row[1:0]) + {2'b00, in_col};

  // the divider restarts on its own quotient until that reaches zero
  assign div_start    = (accept && in_type == REQ_NUMBER) ||
                        (state == ST_CONV && div_res.done && div_res.quot != '0);
  assign div_dividend = (state == ST_IDLE) ? in_number : div_res.quot;

  // digit buffer never overflows for 32-bit values; guard kept anyway
  assign room    = (dcnt < DIG_CNT_W'(MAX_DIGITS));
  assign cnt_new = dcnt + DIG_CNT_W'(room);

  assign init_byte = init_cmd(ptr[2:0]);

  always_comb begin
    breq       = '0;
    breq.valid = (state == ST_SEND);
    unique case (kind)
      REQ_INIT: begin
        breq.rs         = 1'b0;
        breq.value      = init_byte;
        breq.long_hold  = (init_byte == CLEAR_CMD);
        breq.final_byte = (ptr == DIG_IDX_W'(INIT_LEN - 1));
      end
      REQ_NUMBER: begin
        breq.rs         = 1'b1;
        breq.value      = ASCII_ZERO + {4'd0, digits[ptr]};
        breq.final_byte = (ptr == '0);
      end
      default: begin
        breq.rs         = rs_reg;
        breq.value      = byte_reg;
        breq.final_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind <= in_type;
            unique case (in_type)
              REQ_BYTE: begin
                byte_reg <= in_byte;
                rs_reg   <= in_is_data;
                state    <= ST_SEND;
              end
              REQ_INIT: begin
                ptr   <= '0;
                state <= ST_SEND;
              end
              REQ_CURSOR: begin
                // rows above three produce nothing
                if (!in_row[2]) begin
                  byte_reg <= cursor_addr;
                  rs_reg   <= 1'b0;
                  state    <= ST_SEND;
                end
              end
              default: begin
                dcnt  <= '0;
                state <= ST_CONV;
              end
            endcase
          end
        end
        ST_CONV: begin
          if (div_res.done) begin
            if (room) digits[dcnt[DIG_IDX_W-1:0]] <= div_res.rem;
            dcnt <= cnt_new;
            if (div_res.quot == '0) begin
              ptr   <= DIG_IDX_W'(cnt_new - 1'b1);
              state <= ST_SEND;
            end
          end
        end
        ST_SEND: begin
          if (breq_ready) begin
            if (breq.final_byte) begin
              state <= ST_IDLE;
            end else if (kind == REQ_INIT) begin
              ptr <= ptr + 1'b1;
            end else begin
              ptr <= ptr - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lcdnw_div10 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .res      (div_res)
  );

  lcdnw_stepper u_step (
    .clk           (clk),
    .rst           (rst),
    .breq          (breq),
    .breq_ready    (breq_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ src/lcdnw_div10.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Divide by ten through a reciprocal multiply; result valid the cycle after start.
module lcdnw_div10 (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lcdnw_pkg::NUM_W-1:0] dividend,
  output lcdnw_pkg::div_res_t              res
);
  import lcdnw_pkg::*;

  logic                 done;
  logic [NUM_W-1:0]     quot;
  logic [DIG_W-1:0]     num_lo;  // remainder < 10, so the low bits suffice
  logic [2*NUM_W-1:0]   prod;
  logic [DIG_W-1:0]     q10_lo;

  assign prod   = (2*NUM_W)'(dividend) * (2*NUM_W)'(RECIP_10);
  // low bits of quot * 10 = (quot << 3) + (quot << 1)
  assign q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      quot   <= NUM_W'(prod[2*NUM_W-1:RECIP_SHIFT]);
      num_lo <= dividend[DIG_W-1:0];
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = num_lo - q10_lo;

endmodule

`default_nettype wire

@@ src/lcdnw_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Expands one byte into four pin steps and holds each until taken.
module lcdnw_stepper (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcdnw_pkg::byte_req_t breq,
  output logic                     breq_ready,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,  // enable, nibble[3:0], hold_us[11:0], zero pad
  output logic                     m_axis_tuser,  // register_select
  output logic                     m_axis_tlast
);
  import lcdnw_pkg::*;

  logic      busy;
  logic [1:0] phase;  // 0: hi E=1, 1: hi E=0, 2: lo E=1, 3: lo E=0
  byte_req_t cur;
  logic      take;
  logic      end_byte;
  logic [3:0]        nib;
  logic [HOLD_W-1:0] hold;
  logic              en;

  assign end_byte   = m_axis_tready && (phase == 2'd3);
  assign breq_ready = !busy || end_byte;
  assign take       = breq.valid && breq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else begin
      if (take) begin
        busy  <= 1'b1;
        phase <= '0;
        cur   <= breq;
      end else if (busy && m_axis_tready) begin
        phase <= phase + 1'b1;
        if (phase == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_comb begin
    en   = !phase[0];
    nib  = phase[1] ? cur.value[3:0] : cur.value[7:4];
    hold = (phase == 2'd3 && cur.long_hold) ? HOLD_CLEAR : HOLD_STEP;
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {7'd0, hold, nib, en};
  assign m_axis_tuser  = cur.rs;
  assign m_axis_tlast  = cur.final_byte && (phase == 2'd3);

endmodule

`default_nettype wire

@@ src/lcdnw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lcdnw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import lcdnw_pkg::*;

  logic        stalled;
  logic [25:0] m_bus;
  logic        clear_hold;

  assign stalled    = m_axis_tvalid && !m_axis_tready;
  assign m_bus      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign clear_hold = m_axis_tvalid && (m_axis_tdata[16:5] == HOLD_CLEAR);

  // stalled step holds
  `ASSERT_CLK(a_stall_hold, clk, rst, stalled |=> m_axis_tvalid && $stable(m_bus))

  // a request always ends on an E-low step
  `ASSERT_NEVER(a_last_e_low, clk, rst, m_axis_tvalid && m_axis_tlast && m_axis_tdata[0])

  // the long hold only follows the clear command: E low, command mode
  `ASSERT_CLK(a_clear_hold, clk, rst, clear_hold |-> !m_axis_tdata[0] && !m_axis_tuser)

  // out of reset: nothing pending, ready for a request
  `ASSERT_CLK(a_reset, clk, 1'b0, rst |=> !m_axis_tvalid && s_axis_tready)

endmodule

bind char_lcd_nibble_writer lcdnw_checker u_chk (.*);

`default_nettype wire

@@ tb/tb_char_lcd_nibble_writer.sv @@
`timescale 1ns / 1ps

module tb_char_lcd_nibble_writer;
  import lcdnw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_REQS = 460;
  localparam int unsigned CALM_TAIL   = 60;   // requests at the end with no idling
  localparam int unsigned DRAIN_WAIT  = 400;  // quiet cycles to catch stray steps
  localparam logic [11:0] HOLD_TOP    = 12'hFFF;

  // one LCD request as the driver sees it; drain_first holds it back until
  // every step already predicted has been taken
  typedef struct {
    req_t        kind;
    logic        is_data;
    logic [7:0]  byte_value;
    logic [2:0]  row;
    logic [5:0]  column;
    logic [31:0] number;
    bit          drain_first;
  } lcd_req_t;

  // one expected pin step
  typedef struct {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [11:0] hold;
    logic        last;
  } pin_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  lcd_req_t  req_q[$];      // requests still to be sent
  pin_step_t step_q[$];     // pin steps predicted, not yet seen
  lcd_req_t  cur_req;       // request currently on the input bus
  int        total_reqs   = 0;
  int        accepted_cnt = 0;
  int        steps_seen   = 0;
  int        err_cnt      = 0;
  int        gap_left     = 0;
  int        stall_left   = 0;
  int        cycle_cnt    = 0;

  char_lcd_nibble_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------
  // Step prediction
  // --------------------------------------------------------------------

  // four steps per byte: hi nibble E high, E low, lo nibble E high, E low;
  // only the very last step of the byte may carry the clear delay
  function automatic void push_lcd_byte(input logic rs, input logic [7:0] b,
                                        input bit clear_delay);
    pin_step_t   s;
    int unsigned us;
    us = STEP_HOLD_US + (clear_delay ? CLEAR_EXTRA_US : 0);
    s.rs   = rs;
    s.last = 1'b0;
    s.hold = (STEP_HOLD_US > HOLD_TOP) ? HOLD_TOP : STEP_HOLD_US[11:0];
    s.en = 1'b1; s.nib = b[7:4]; step_q.push_back(s);
    s.en = 1'b0;                 step_q.push_back(s);
    s.en = 1'b1; s.nib = b[3:0]; step_q.push_back(s);
    s.en = 1'b0;
    s.hold = (us > HOLD_TOP) ? HOLD_TOP : us[11:0];
    step_q.push_back(s);
  endfunction

  function automatic void predict_lcd_steps(input lcd_req_t r);
    logic [7:0]  init_seq [6];
    logic [7:0]  base_addr [4];
    logic [7:0]  digit_chars [10];
    logic [31:0] v;
    int          n_digits;
    int          first_idx;
    init_seq  = '{8'h33, 8'h32, 8'h28, 8'h0E, CLEAR_CMD, 8'h06};
    base_addr = '{8'h00, 8'h40, 8'h14, 8'h54};
    first_idx = step_q.size();
    case (r.kind)
      REQ_BYTE: begin
        push_lcd_byte(r.is_data, r.byte_value, 1'b0);
      end
      REQ_INIT: begin
        for (int i = 0; i < 6; i++)
          push_lcd_byte(1'b0, init_seq[i], init_seq[i] == CLEAR_CMD);
      end
      REQ_CURSOR: begin
        // rows above three make no command at all
        if (r.row < 3'd4)
          push_lcd_byte(1'b0, SET_DDRAM + base_addr[r.row[1:0]] + {2'b00, r.column}, 1'b0);
      end
      default: begin
        // decimal, least significant digit found first; zero gives one '0'
        v = r.number;
        n_digits = 0;
        do begin
          digit_chars[n_digits] = ASCII_ZERO + 8'(v % 10);
          n_digits++;
          v = v / 10;
        end while (v != 0);
        for (int i = n_digits - 1; i >= 0; i--)
          push_lcd_byte(1'b1, digit_chars[i], 1'b0);
      end
    endcase
    if (step_q.size() > first_idx)
      step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------
  wire calm     = (accepted_cnt + CALM_TAIL >= total_reqs);
  wire tx_noisy = ((accepted_cnt / 40) % 2) == 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lcd_steps(cur_req);
        accepted_cnt++;
      end
      // bus free for the next request?
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0 && req_q[0].drain_first && step_q.size() > 0) begin
          s_axis_tvalid <= 1'b0;  // hold off until the output side is empty
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= {7'd0, cur_req.number, cur_req.column, cur_req.row,
                            cur_req.byte_value};
          s_axis_tuser  <= {cur_req.is_data, cur_req.kind};
          s_axis_tvalid <= 1'b1;
          if (!calm && tx_noisy && $urandom_range(0, 2) == 0)
            gap_left = $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------
  // Step monitor and receiver stalls
  // --------------------------------------------------------------------
  wire rx_noisy = ((steps_seen / 64) % 3) != 2;

  always @(posedge clk) begin
    pin_step_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        steps_seen++;
        if (step_q.size() == 0) begin
          $display("%0t: unexpected step: rs=%0b en=%0b nib=%h hold=%0d last=%0b",
                   $time, m_axis_tuser, m_axis_tdata[0], m_axis_tdata[4:1],
                   m_axis_tdata[16:5], m_axis_tlast);
          err_cnt++;
        end else begin
          want = step_q.pop_front();
          if (m_axis_tuser !== want.rs) begin
            $display("%0t: rs mismatch: expected %0b, actual %0b", $time, want.rs, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[0] !== want.en) begin
            $display("%0t: enable mismatch: expected %0b, actual %0b",
                     $time, want.en, m_axis_tdata[0]);
            err_cnt++;
          end
          if (m_axis_tdata[4:1] !== want.nib) begin
            $display("%0t: nibble mismatch: expected %h, actual %h",
                     $time, want.nib, m_axis_tdata[4:1]);
            err_cnt++;
          end
          if (m_axis_tdata[16:5] !== want.hold) begin
            $display("%0t: hold_us mismatch: expected %0d, actual %0d",
                     $time, want.hold, m_axis_tdata[16:5]);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && rx_noisy && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 10);
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------
  function automatic void add_req(input req_t kind, input logic is_data,
                                  input logic [7:0] b, input logic [2:0] row,
                                  input logic [5:0] col, input logic [31:0] num,
                                  input bit drain_first);
    lcd_req_t r;
    r.kind        = kind;
    r.is_data     = is_data;
    r.byte_value  = b;
    r.row         = row;
    r.column      = col;
    r.number      = num;
    r.drain_first = drain_first;
    req_q.push_back(r);
  endfunction

  initial begin
    int   pick;
    req_t kind;

    // directed: byte extremes, init, all rows incl. wrap and dead rows,
    // number extremes; unused fields carry junk
    add_req(REQ_BYTE,   1'b0, 8'h00, 3'd7, 6'd63, 32'hFFFF_FFFF, 0);
    add_req(REQ_BYTE,   1'b1, 8'hFF, 3'd0, 6'd0,  32'h0, 0);
    add_req(REQ_BYTE,   1'b0, 8'hA5, 3'd5, 6'd21, 32'h1234_5678, 0);
    add_req(REQ_BYTE,   1'b1, 8'h5A, 3'd2, 6'd42, 32'h8765_4321, 0);
    add_req(REQ_INIT,   1'b1, 8'hFF, 3'd7, 6'd63, 32'hFFFF_FFFF, 0);
    add_req(REQ_CURSOR, 1'b1, 8'hFF, 3'd0, 6'd0,  32'hFFFF_FFFF, 0);
    add_req(REQ_CURSOR, 1'b0, 8'h00, 3'd0, 6'd63, 32'h0, 0);
    add_req(REQ_CURSOR, 1'b1, 8'h3C, 3'd1, 6'd0,  32'h0, 0);
    add_req(REQ_CURSOR, 1'b0, 8'hC3, 3'd1, 6'd63, 32'h0, 0);
    add_req(REQ_CURSOR, 1'b0, 8'h00, 3'd2, 6'd63, 32'h0, 0);
    add_req(REQ_CURSOR, 1'b0, 8'h00, 3'd3, 6'd63, 32'h0, 0);  // address wraps
    add_req(REQ_CURSOR, 1'b0, 8'h00, 3'd4, 6'd10, 32'h0, 0);  // no steps
    add_req(REQ_CURSOR, 1'b1, 8'hFF, 3'd7, 6'd63, 32'h0, 0);  // no steps
    add_req(REQ_NUMBER, 1'b0, 8'h11, 3'd6, 6'd5,  32'd0, 1);  // zero prints '0'
    add_req(REQ_NUMBER, 1'b1, 8'hEE, 3'd1, 6'd9,  32'd9, 0);
    add_req(REQ_NUMBER, 1'b0, 8'h00, 3'd0, 6'd0,  32'd10, 0);
    add_req(REQ_NUMBER, 1'b1, 8'hFF, 3'd7, 6'd63, 32'hFFFF_FFFF, 0);
    add_req(REQ_NUMBER, 1'b0, 8'h00, 3'd0, 6'd0,  32'd1_000_000_000, 0);
    add_req(REQ_NUMBER, 1'b0, 8'h00, 3'd0, 6'd0,  32'd999_999_999, 0);
    add_req(REQ_INIT,   1'b0, 8'h00, 3'd0, 6'd0,  32'h0, 1);
    add_req(REQ_BYTE,   1'b1, 8'h30, 3'd0, 6'd0,  32'h0, 0);

    // random: weighted kinds, numbers spread over all digit counts
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = REQ_BYTE;
      else if (pick < 43) kind = REQ_INIT;
      else if (pick < 68) kind = REQ_CURSOR;
      else                kind = REQ_NUMBER;
      add_req(kind, 1'($urandom), 8'($urandom), 3'($urandom), 6'($urandom),
              $urandom >> $urandom_range(0, 31), (i % 150) == 75);
    end
    total_reqs = req_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (step_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/lcdnw_pkg.sv
src/lcdnw_div10.sv
src/lcdnw_stepper.sv
src/char_lcd_nibble_writer.sv
src/lcdnw_checker.sv
tb/tb_char_lcd_nibble_writer.sv
